// ===== src/distance_depth_sorter_macros.svh =====
// assertion macros for the distance depth sorter
`ifndef DISTANCE_DEPTH_SORTER_MACROS_SVH
`define DISTANCE_DEPTH_SORTER_MACROS_SVH

`ifndef SYNTHESIS

`define DDS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("dds assertion failed");

`define DDS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("dds assertion failed");

`else

`define DDS_ASSERT_IMPL(label, clk, rst_n, pre, post)

`define DDS_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== src/dds_pkg.sv =====
`timescale 1ns / 1ps

package dds_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int COORD_W   = 24;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = SQ_W + 1;
	localparam int SLOT_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 2'd1;

	typedef struct packed {
		logic accept;
		logic scan_clear;
		logic scan_rd;
		logic emit;
		logic set_clear;
	} dds_cmd_t;

	typedef struct packed {
		logic wr_last;
		logic scan_end;
		logic out_free;
		logic final_pick;
	} dds_sts_t;

endpackage

// ===== src/dds_ctrl.sv =====
`timescale 1ns / 1ps

module dds_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	input  dds_pkg::dds_sts_t sts,
	output dds_pkg::dds_cmd_t cmd
);
	import dds_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_WAIT = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_PICK = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		s_tready       = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.wr_last) begin
					cmd.scan_clear = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = ST_PICK;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_PICK: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.final_pick) begin
						cmd.set_clear = 1'b1;
						state_d       = ST_LOAD;
					end else begin
						cmd.scan_clear = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/dds_datapath.sv =====
`timescale 1ns / 1ps
`include "distance_depth_sorter_macros.svh"

module dds_datapath #(
	parameter int SLOTS = dds_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [dds_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dds_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dds_pkg::COORD_W-1:0]      cfg_data,
	input  dds_pkg::dds_cmd_t                cmd,
	output dds_pkg::dds_sts_t                sts
);
	import dds_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic signed [COORD_W-1:0] viewer_x_q, viewer_y_q;
	logic [CW-1:0]             count_q, scan_q, emit_q;
	logic [SLOTS-1:0]          used_q;

	logic signed [COORD_W-1:0] obj_x, obj_y;
	logic                      wr_en_s1, last_s1, wr_en_s2, last_s2;
	logic [IW-1:0]             wr_addr_s1, wr_addr_s2;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic signed [2*DIFF_W-1:0] px, py;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2;
	logic [DIST_W-1:0]         wr_dist;

	logic [DIST_W-1:0]         mem_q [SLOTS];
	logic [DIST_W-1:0]         rd_dist_s1;
	logic [IW-1:0]             cmp_addr_s1;
	logic                      cmp_vld_s1;
	logic                      take;

	logic                      found_q;
	logic [DIST_W-1:0]         best_dist_q;
	logic [IW-1:0]             best_idx_q;

	logic                      out_valid_q, out_last_q;
	logic [SLOT_W-1:0]         out_idx_q;
	logic [DIST_W-1:0]         out_dist_q;

	// viewer position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q <= '0;
			viewer_y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VIEWER_X: viewer_x_q <= cfg_data;
				CFG_VIEWER_Y: viewer_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// distance pipeline
	assign obj_x = s_tdata[COORD_W-1:0];
	assign obj_y = s_tdata[2*COORD_W-1:COORD_W];
	assign px    = dx_s1 * dx_s1;
	assign py    = dy_s1 * dy_s1;
	assign wr_dist = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			last_s1  <= 1'b0;
			wr_en_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.accept && (count_q < CW'(SLOTS));
			last_s1  <= cmd.accept && s_tlast;
			wr_en_s2 <= wr_en_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= count_q[IW-1:0];
		dx_s1      <= DIFF_W'(obj_x) - DIFF_W'(viewer_x_q);
		dy_s1      <= DIFF_W'(obj_y) - DIFF_W'(viewer_y_q);
		wr_addr_s2 <= wr_addr_s1;
		sqx_s2     <= px[SQ_W-1:0];
		sqy_s2     <= py[SQ_W-1:0];
	end

	// distance store
	always_ff @(posedge clk) begin
		if (wr_en_s2) begin
			mem_q[wr_addr_s2] <= wr_dist;
		end
		if (cmd.scan_rd) begin
			rd_dist_s1 <= mem_q[scan_q[IW-1:0]];
		end
		cmp_addr_s1 <= scan_q[IW-1:0];
	end

	// selection scan: farthest unused slot, lower slot wins ties
	assign take = cmp_vld_s1 && !used_q[cmp_addr_s1] &&
		(!found_q || (rd_dist_s1 > best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_q     <= '0;
			emit_q     <= '0;
			used_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_clear) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_q <= scan_q + CW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.set_clear) begin
				count_q <= '0;
				used_q  <= '0;
				emit_q  <= '0;
			end else begin
				if (cmd.accept && (count_q < CW'(SLOTS))) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.emit) begin
					used_q[best_idx_q] <= 1'b1;
					emit_q             <= emit_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= rd_dist_s1;
			best_idx_q  <= cmp_addr_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q  <= SLOT_W'(best_idx_q);
			out_dist_q <= best_dist_q;
			out_last_q <= sts.final_pick;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_dist_q, out_idx_q});
	assign m_tlast  = out_last_q;

	assign sts.wr_last    = last_s2;
	assign sts.scan_end   = (scan_q == count_q);
	assign sts.out_free   = !out_valid_q || m_tready;
	assign sts.final_pick = ((emit_q + CW'(1)) == count_q);

	`DDS_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, (!out_valid_q || m_tready))
	`DDS_ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, (count_q <= CW'(SLOTS)))
	`DDS_ASSERT_IMPL(a_scan_range, clk, arst_n, cmd.scan_rd, (scan_q < count_q))
	`DDS_ASSERT_NEXT(a_set_cleared, clk, arst_n, (cmd.emit && sts.final_pick),
		(count_q == '0 && used_q == '0))

endmodule

// ===== src/distance_depth_sorter.sv =====
`timescale 1ns / 1ps
// loading takes one item per cycle; a last item passes registers s1 and s2 before the store
// each result is found by a scan of the n loaded slots through the store's read port
// a full set of n results takes n such scans, and any stall on the output holds the sort
// input is not taken while results are being sorted out; a new set loads as the last result waits
// reset clears the viewer position, the slot count and the control state; stores keep no reset

module distance_depth_sorter #(
	parameter int SLOTS = dds_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dds_pkg::IN_DATA_W-1:0]    s_tdata,   // object_x, object_y
	input  logic                             s_tlast,   // last_object
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dds_pkg::OUT_DATA_W-1:0]   m_tdata,   // slot_index, distance_sq, zero pad
	output logic                             m_tlast,   // last_result
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dds_pkg::COORD_W-1:0]      cfg_data
);
	import dds_pkg::*;

	dds_cmd_t cmd;
	dds_sts_t sts;

	assign cfg_ready = 1'b1;

	dds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dds_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== tb/distance_depth_sorter_tb.sv =====
`timescale 1ns / 1ps

module distance_depth_sorter_tb;
	import dds_pkg::*;

	localparam int SLOTS         = SLOTS_DEF;
	localparam int HALF_PERIOD   = 10;
	localparam int RANDOM_ITEMS  = 480;
	localparam int IDLE_PCT      = 38;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic [COORD_W-1:0] COORD_MIN  = 24'h800000;
	localparam logic [COORD_W-1:0] COORD_MAX  = 24'h7fffff;
	localparam logic [COORD_W-1:0] COORD_ZERO = 24'h000000;
	localparam logic [COORD_W-1:0] COORD_NEG1 = 24'hffffff;

	typedef enum logic {ROW_OBJECT, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic                  last;
		logic                  typed;
		logic [DIST_W-1:0]     want;
	} stim_row_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_index;
		logic [DIST_W-1:0]  distance_sq;
		logic               last_result;
	} depth_entry_t;

	// config rows carry the register value in x
	localparam int N_DIRECTED = 21;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_ZERO, COORD_ZERO, 1'b1, 1'b1, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 49'h0_8000_0000_0000},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MAX, COORD_MAX, 1'b1, 1'b1, 49'h0_7fff_fe00_0002},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_NEG1, COORD_ZERO, 1'b1, 1'b1, 49'd1},
		'{ROW_CONFIG, CFG_VIEWER_X, COORD_MIN, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_CONFIG, CFG_VIEWER_Y, COORD_MAX, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MAX, COORD_MIN, 1'b1, 1'b1, 49'h1_ffff_fc00_0002},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MIN, COORD_MAX, 1'b1, 1'b1, 49'd0},
		'{ROW_CONFIG, CFG_SPARE_2, 24'ha5a5a5, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_CONFIG, CFG_SPARE_3, 24'h5a5a5a, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MIN, COORD_MAX, 1'b1, 1'b1, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, 24'h800003, COORD_MAX, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MIN, 24'h7ffffc, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, 24'h800001, COORD_MAX, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_MAX, COORD_MIN, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, 24'h800003, COORD_MAX, 1'b1, 1'b0, 49'd0},
		'{ROW_CONFIG, CFG_VIEWER_X, COORD_ZERO, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_CONFIG, CFG_VIEWER_Y, COORD_ZERO, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_ZERO, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, 24'h000100, COORD_ZERO, 1'b0, 1'b0, 49'd0},
		'{ROW_OBJECT, CFG_VIEWER_X, COORD_ZERO, 24'hffff00, 1'b1, 1'b0, 49'd0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata;   // object_x, object_y
	logic                    s_tlast;   // last_object
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;   // slot_index, distance_sq, zero pad
	logic                    m_tlast;   // last_result
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [COORD_W-1:0]      cfg_data;

	// predictor state
	logic [COORD_W-1:0]  viewer_x;
	logic [COORD_W-1:0]  viewer_y;
	logic [DIST_W-1:0]   slot_distance [SLOTS];
	int                  loaded;
	depth_entry_t        pending_results [$];

	bit  steady;
	bit  hold_req;
	int  errors;
	int  results_seen;
	int  reg_writes;
	int  sets_sent;
	int  overflow_sets;
	int  dropped_items;
	int  random_items;
	int  quiet_cycles;

	distance_depth_sorter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [DIST_W-1:0] squared_reach(input logic [COORD_W-1:0] ox,
			input logic [COORD_W-1:0] oy);
		longint dx;
		longint dy;
		dx = longint'($signed(ox)) - longint'($signed(viewer_x));
		dy = longint'($signed(oy)) - longint'($signed(viewer_y));
		return DIST_W'(dx * dx + dy * dy);
	endfunction

	// stable insertion, farthest first
	function automatic void record_object(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic last, input logic typed, input logic [DIST_W-1:0] want);
		depth_entry_t ranked [$];
		depth_entry_t entry;
		int i;
		int p;
		if (loaded < SLOTS) begin
			slot_distance[loaded] = squared_reach(x, y);
			loaded++;
		end
		if (!last)
			return;
		if (typed) begin
			entry.slot_index = '0;
			entry.distance_sq = want;
			entry.last_result = 1'b1;
			pending_results.push_back(entry);
			loaded = 0;
			return;
		end
		for (i = 0; i < loaded; i++) begin
			entry.slot_index = SLOT_W'(i);
			entry.distance_sq = slot_distance[i];
			entry.last_result = 1'b0;
			p = 0;
			while (p < ranked.size() && ranked[p].distance_sq >= entry.distance_sq)
				p++;
			ranked.insert(p, entry);
		end
		for (i = 0; i < ranked.size(); i++) begin
			entry = ranked[i];
			entry.last_result = (i == ranked.size() - 1);
			pending_results.push_back(entry);
		end
		loaded = 0;
	endfunction

	function automatic int sender_gap();
		int n;
		n = 0;
		if (steady)
			return 0;
		while (n < 20 && $urandom_range(99) < IDLE_PCT)
			n++;
		return n;
	endfunction

	function automatic logic [COORD_W-1:0] extreme_coord();
		case ($urandom_range(3))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return COORD_ZERO;
			default: return COORD_NEG1;
		endcase
	endfunction

	function automatic logic [CFG_IDX_W-1:0] pick_register();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return CFG_VIEWER_X;
		else if (r < 8)
			return CFG_VIEWER_Y;
		else if (r == 8)
			return CFG_SPARE_2;
		else
			return CFG_SPARE_3;
	endfunction

	function automatic logic [COORD_W-1:0] pick_setting();
		if ($urandom_range(2) == 0)
			return extreme_coord();
		else
			return COORD_W'($urandom);
	endfunction

	function automatic int set_size(input int k);
		int r;
		r = $urandom_range(99);
		if (k == 0)
			return SLOTS;
		else if (k == 1)
			return SLOTS + 1;
		else if (k == 2)
			return SLOTS + 2 + $urandom_range(6);
		else if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 92)
			return $urandom_range(9, SLOTS - 1);
		else
			return $urandom_range(SLOTS, SLOTS + 8);
	endfunction

	task automatic send_object(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic last, input logic typed, input logic [DIST_W-1:0] want);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		record_object(x, y, last, typed, want);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [COORD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (index == CFG_VIEWER_X)
			viewer_x = value;
		else if (index == CFG_VIEWER_Y)
			viewer_y = value;
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_set(input int size);
		logic [IN_DATA_W-1:0] seen [$];
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		int i;
		int mode;
		for (i = 0; i < size; i++) begin
			mode = $urandom_range(9);
			if (mode < 5 || (mode >= 8 && seen.size() == 0)) begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
			end else if (mode < 7) begin
				// near the viewer
				x = COORD_W'(viewer_x + $urandom_range(512) - 256);
				y = COORD_W'(viewer_y + $urandom_range(512) - 256);
			end else if (mode == 7) begin
				x = extreme_coord();
				y = extreme_coord();
			end else begin
				// repeat an earlier position for an exact tie
				{y, x} = seen[$urandom_range(seen.size() - 1)];
			end
			seen.push_back({y, x});
			send_object(x, y, i == size - 1, 1'b0, '0);
			if (i < SLOTS)
				random_items++;
			else
				dropped_items++;
		end
		sets_sent++;
		if (size > SLOTS)
			overflow_sets++;
	endtask

	// receiver side
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_results
		depth_entry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with none expected: slot_index %0d distance_sq %0h",
					m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: DIST_W]);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[SLOT_W-1:0] !== want.slot_index) begin
					$error("slot_index: expected %0d, actual %0d", want.slot_index,
						m_tdata[SLOT_W-1:0]);
					errors++;
				end
				if (m_tdata[SLOT_W +: DIST_W] !== want.distance_sq) begin
					$error("distance_sq: expected %0h, actual %0h", want.distance_sq,
						m_tdata[SLOT_W +: DIST_W]);
					errors++;
				end
				if (m_tlast !== want.last_result) begin
					$error("last_result: expected %0b, actual %0b", want.last_result, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		int phase;
		int n_sets;
		int n_writes;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_VIEWER_X;
		cfg_data <= '0;
		viewer_x = '0;
		viewer_y = '0;
		loaded = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		errors = 0;
		results_seen = 0;
		reg_writes = 0;
		sets_sent = 0;
		overflow_sets = 0;
		dropped_items = 0;
		random_items = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			row = DIRECTED[r];
			if (row.kind == ROW_CONFIG) begin
				wait_for_results();
				write_register(row.index, row.x);
			end else begin
				send_object(row.x, row.y, row.last, row.typed, row.want);
			end
		end

		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_for_results();
			steady = (phase == 4);
			n_writes = $urandom_range(1, 3);
			for (int w = 0; w < n_writes; w++)
				write_register(pick_register(), pick_setting());
			// output held off while sets keep coming
			if (phase == 2)
				hold_req = 1'b1;
			n_sets = $urandom_range(2, 5);
			for (int s = 0; s < n_sets; s++)
				send_set(set_size(sets_sent));
			phase++;
		end
		wait_for_results();
		repeat (2 * SLOTS) @(posedge clk);

		$display("ran %0d random objects in %0d sets, %0d sets past %0d slots (%0d dropped)",
			random_items, sets_sent, overflow_sets, SLOTS, dropped_items);
		$display("checked %0d sorted results across %0d register writes", results_seen,
			reg_writes);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/dds_pkg.sv
src/dds_ctrl.sv
src/dds_datapath.sv
src/distance_depth_sorter.sv
tb/distance_depth_sorter_tb.sv
